### src/dqle_pkg.sv
// dqle_pkg: shared constants and types of the dns qname label encoder
// used by every module of the block but dqle_ram, no dependencies of its own

package dqle_pkg;

	// default and widest label length
	localparam int LABEL_MAX_DEF = 63;
	localparam int CNT_W = 6;

	// label store: two banks of one label each, address is {bank, index}
	localparam int MEM_AW = CNT_W + 1;
	localparam int MEM_DEPTH = 1 << MEM_AW;

	localparam int CMD_DEPTH = 2;

	localparam logic [7:0] DOT_CHAR = 8'h2E;

	// input kind codes
	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_TRAILER = 2'd2;

	typedef enum logic {
		OP_FLUSH,
		OP_TRAILER
	} op_t;

	typedef struct packed {
		op_t op;
		logic bank;
		logic [CNT_W-1:0] count;
		logic [15:0] qtype;
		logic [15:0] qclass;
		logic ovf;
	} cmd_t;

	// back end hands a replayed bank back to the front end
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

endpackage

### src/dqle_ram.sv
// dqle_ram: generic single-write, single-read ram with registered read data
// no dependencies

module dqle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/dqle_cmd_fifo.sv
// dqle_cmd_fifo: short command queue between front and back end
// depends on dqle_pkg for the command type

module dqle_cmd_fifo #(
	parameter int DEPTH = dqle_pkg::CMD_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dqle_pkg::cmd_t data_in,
	output logic           full,
	input  logic           pop,
	output dqle_pkg::cmd_t data_out,
	output logic           not_empty
);

	localparam int PW = $clog2(DEPTH);

	dqle_pkg::cmd_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   fill_q;

	assign full = fill_q == (PW+1)'(DEPTH);
	assign not_empty = fill_q != '0;
	assign data_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			priority if (push && !pop) begin
				fill_q <= fill_q + (PW+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (PW+1)'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full command queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty command queue");

endmodule

### src/dqle_front.sv
// dqle_front: accepts name words, buffers label characters, queues commands
// depends on dqle_pkg; writes the label ram, feeds dqle_cmd_fifo

module dqle_front #(
	parameter int LABEL_MAX = dqle_pkg::LABEL_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  kind,
	input  logic [7:0]                  char_byte,
	input  logic [15:0]                 query_type,
	input  logic [15:0]                 query_class,
	input  logic                        cmd_full,
	output logic                        cmd_push,
	output dqle_pkg::cmd_t              cmd_data,
	input  dqle_pkg::release_t          rel,
	output logic                        mem_we,
	output logic [dqle_pkg::MEM_AW-1:0] mem_waddr,
	output logic [7:0]                  mem_wdata
);

	localparam int CW = dqle_pkg::CNT_W;

	logic [CW-1:0] label_count_q;
	logic          at_start_q;
	logic          ovf_q;
	logic          bank_q;
	logic [1:0]    busy_q;
	logic [1:0]    busy_d;

	logic is_char;
	logic is_dot;
	logic room;
	logic need_push;
	logic need_write;
	logic acc;

	assign is_char = kind == dqle_pkg::KIND_CHAR;
	assign is_dot = char_byte == dqle_pkg::DOT_CHAR;
	assign room = label_count_q < CW'(LABEL_MAX);
	assign need_push = (is_char && is_dot && !at_start_q) || kind == dqle_pkg::KIND_END
		|| kind == dqle_pkg::KIND_TRAILER;
	assign need_write = is_char && !is_dot && room;

	// a character to be stored waits only while its bank is still queued for replay
	assign in_ready = need_push ? !cmd_full : (need_write ? !busy_q[bank_q] : 1'b1);
	assign acc = in_valid && in_ready;

	assign cmd_push = acc && need_push;
	assign cmd_data.op = (kind == dqle_pkg::KIND_TRAILER) ? dqle_pkg::OP_TRAILER
		: dqle_pkg::OP_FLUSH;
	assign cmd_data.bank = bank_q;
	assign cmd_data.count = label_count_q;
	assign cmd_data.qtype = query_type;
	assign cmd_data.qclass = query_class;
	assign cmd_data.ovf = ovf_q;

	assign mem_we = acc && need_write;
	assign mem_waddr = {bank_q, label_count_q};
	assign mem_wdata = char_byte;

	// an empty label reads nothing, so it neither holds nor releases its bank
	always_comb begin
		busy_d = busy_q;
		if (rel.valid) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (cmd_push && kind != dqle_pkg::KIND_TRAILER && label_count_q != '0) begin
			busy_d[bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_count_q <= '0;
			at_start_q <= 1'b1;
			ovf_q <= 1'b0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			busy_q <= busy_d;
			if (acc) begin
				unique case (kind)
					dqle_pkg::KIND_CHAR: begin
						if (is_dot) begin
							if (at_start_q) begin
								at_start_q <= 1'b0;
							end else begin
								label_count_q <= '0;
								bank_q <= ~bank_q;
							end
						end else begin
							at_start_q <= 1'b0;
							if (room) begin
								label_count_q <= label_count_q + CW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end
					dqle_pkg::KIND_END: begin
						label_count_q <= '0;
						at_start_q <= 1'b1;
						bank_q <= ~bank_q;
					end
					dqle_pkg::KIND_TRAILER: begin
						// buffered characters of an unterminated name are dropped
						label_count_q <= '0;
						at_start_q <= 1'b1;
						ovf_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_write_free_bank: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !busy_q[bank_q]) else $error("label write into bank awaiting replay");

endmodule

### src/dqle_back.sv
// dqle_back: executes queued commands, replays labels and emits trailer bytes
// depends on dqle_pkg; reads the label ram, releases banks to dqle_front

module dqle_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  dqle_pkg::cmd_t              cmd_data,
	output logic                        cmd_pop,
	output logic                        mem_re,
	output logic [dqle_pkg::MEM_AW-1:0] mem_raddr,
	input  logic [7:0]                  mem_rdata,
	output dqle_pkg::release_t          rel,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic                        is_last,
	output logic                        label_overflow
);

	localparam int CW = dqle_pkg::CNT_W;

	localparam logic [2:0] STEP_TERM = 3'd0;
	localparam logic [2:0] STEP_TYPE_HI = 3'd1;
	localparam logic [2:0] STEP_TYPE_LO = 3'd2;
	localparam logic [2:0] STEP_CLASS_HI = 3'd3;
	localparam logic [2:0] STEP_CLASS_LO = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEN,
		ST_DATA,
		ST_TRL
	} state_t;

	state_t         state_q;
	dqle_pkg::cmd_t cmd_q;
	logic [CW-1:0]  idx_q;
	logic [2:0]     step_q;
	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic           is_last_q;
	logic           ovf_out_q;

	logic       can_load;
	logic       last_idx;
	logic [7:0] trl_byte;
	logic       trl_last;

	assign can_load = !out_valid_q || out_ready;
	assign last_idx = idx_q == cmd_q.count - CW'(1);
	assign cmd_pop = state_q == ST_IDLE && cmd_valid;
	assign trl_last = step_q == STEP_CLASS_LO;

	always_comb begin
		unique case (step_q)
			STEP_TERM:     trl_byte = 8'h00;
			STEP_TYPE_HI:  trl_byte = cmd_q.qtype[15:8];
			STEP_TYPE_LO:  trl_byte = cmd_q.qtype[7:0];
			STEP_CLASS_HI: trl_byte = cmd_q.qclass[15:8];
			default:       trl_byte = cmd_q.qclass[7:0];
		endcase
	end

	// read of the next character is issued as the current byte is loaded
	always_comb begin
		mem_re = 1'b0;
		mem_raddr = {cmd_q.bank, idx_q + CW'(1)};
		rel.valid = 1'b0;
		rel.bank = cmd_q.bank;
		unique case (state_q)
			ST_LEN: begin
				mem_re = can_load && cmd_q.count != '0;
				mem_raddr = {cmd_q.bank, {CW{1'b0}}};
			end
			ST_DATA: begin
				mem_re = can_load && !last_idx;
				rel.valid = can_load && last_idx;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q <= '0;
			out_valid_q <= 1'b0;
			out_byte_q <= '0;
			is_last_q <= 1'b0;
			ovf_out_q <= 1'b0;
			idx_q <= '0;
			step_q <= STEP_TERM;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd_data;
						step_q <= STEP_TERM;
						state_q <= (cmd_data.op == dqle_pkg::OP_TRAILER) ? ST_TRL : ST_LEN;
					end
				end
				ST_LEN: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						out_byte_q <= 8'(cmd_q.count);
						is_last_q <= 1'b0;
						ovf_out_q <= 1'b0;
						idx_q <= '0;
						state_q <= (cmd_q.count == '0) ? ST_IDLE : ST_DATA;
					end
				end
				ST_DATA: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						out_byte_q <= mem_rdata;
						is_last_q <= 1'b0;
						ovf_out_q <= 1'b0;
						if (last_idx) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				ST_TRL: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						out_byte_q <= trl_byte;
						is_last_q <= trl_last;
						ovf_out_q <= trl_last && cmd_q.ovf;
						if (trl_last) begin
							state_q <= ST_IDLE;
						end else begin
							step_q <= step_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign is_last = is_last_q;
	assign label_overflow = ovf_out_q;

	a_ovf_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ovf_out_q |-> is_last_q) else $error("overflow flag off the last word");
	a_idx_in_label: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DATA |-> idx_q < cmd_q.count) else $error("replay index past label");
	a_release_once: assert property (@(posedge clk) disable iff (!arst_n)
		rel.valid |=> state_q == ST_IDLE) else $error("bank released before replay ended");

endmodule

### src/dns_qname_label_encoder.sv
// dns_qname_label_encoder: top level of the dns question name encoder
// depends on dqle_pkg, dqle_ram, dqle_cmd_fifo, dqle_front, dqle_back
//
// The front end takes one input word per cycle unless it stalls: a name
// character within the label limit is written into the label ram, and a
// closing dot, end or trailer word queues a command. The back end runs the
// commands: a label of n characters goes out as n+1 bytes and a trailer as
// five bytes, one byte per cycle while out_ready allows. The label ram has
// two banks, so a new label fills while the previous one is replayed; a
// character word stalls only when its bank still waits for replay, and a
// closing dot, end or trailer word stalls while the two-entry command queue
// is full. Output bytes come from a register, so the input side keeps moving
// while a byte waits on out_ready. No clearing pass is run after reset.

module dns_qname_label_encoder #(
	parameter int LABEL_MAX = dqle_pkg::LABEL_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  char_byte,
	input  logic [15:0] query_type,
	input  logic [15:0] query_class,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        is_last,
	output logic        label_overflow
);

	logic                        cmd_full;
	logic                        cmd_push;
	dqle_pkg::cmd_t              cmd_in;
	logic                        cmd_pop;
	dqle_pkg::cmd_t              cmd_out;
	logic                        cmd_valid;
	dqle_pkg::release_t          rel;
	logic                        mem_we;
	logic [dqle_pkg::MEM_AW-1:0] mem_waddr;
	logic [7:0]                  mem_wdata;
	logic                        mem_re;
	logic [dqle_pkg::MEM_AW-1:0] mem_raddr;
	logic [7:0]                  mem_rdata;

	dqle_front #(
		.LABEL_MAX(LABEL_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.char_byte  (char_byte),
		.query_type (query_type),
		.query_class(query_class),
		.cmd_full   (cmd_full),
		.cmd_push   (cmd_push),
		.cmd_data   (cmd_in),
		.rel        (rel),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata)
	);

	dqle_cmd_fifo #(
		.DEPTH(dqle_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.data_in  (cmd_in),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.data_out (cmd_out),
		.not_empty(cmd_valid)
	);

	dqle_ram #(
		.WIDTH(8),
		.DEPTH(dqle_pkg::MEM_DEPTH)
	) u_label_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	dqle_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_data      (cmd_out),
		.cmd_pop       (cmd_pop),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata),
		.rel           (rel),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.is_last       (is_last),
		.label_overflow(label_overflow)
	);

endmodule

### tb/dqle_wire_checker.sv
`timescale 1ns / 1ps
// dqle_wire_checker: follows accepted name words, predicts the wire-format bytes
// of the question and compares them with every accepted output word
// depends on dqle_pkg for kind codes, the dot character and the label limits

module dqle_wire_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  char_byte,
	input  logic [15:0] query_type,
	input  logic [15:0] query_class,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic        is_last,
	input  logic        label_overflow,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		logic [7:0] val;
		logic       last;
		logic       ovf;
	} wire_byte_t;

	wire_byte_t                 bytes_due[$];
	logic [7:0]                 label_chars [dqle_pkg::LABEL_MAX_DEF];
	logic [dqle_pkg::CNT_W-1:0] label_len;
	logic                       name_start;
	logic                       trunc_seen;
	int                         fails = 0;
	int                         due_cnt = 0;

	assign fail_count = fails;
	assign pending = due_cnt;

	task automatic push_byte(input logic [7:0] v, input logic l, input logic o);
		wire_byte_t wb;
		wb.val = v;
		wb.last = l;
		wb.ovf = o;
		bytes_due.push_back(wb);
	endtask

	// length byte, then the held characters
	task automatic emit_label();
		push_byte(8'(label_len), 1'b0, 1'b0);
		for (int i = 0; i < label_len; i++) begin
			push_byte(label_chars[i], 1'b0, 1'b0);
		end
		label_len = '0;
	endtask

	task automatic encode_word(input logic [1:0] k, input logic [7:0] c,
			input logic [15:0] qt, input logic [15:0] qc);
		case (k)
			dqle_pkg::KIND_CHAR: begin
				if (c == dqle_pkg::DOT_CHAR) begin
					// a dot opening a name only starts the first label
					if (name_start)
						name_start = 1'b0;
					else
						emit_label();
				end else begin
					name_start = 1'b0;
					if (label_len < dqle_pkg::LABEL_MAX_DEF) begin
						label_chars[label_len] = c;
						label_len = label_len + 1'b1;
					end else begin
						trunc_seen = 1'b1;
					end
				end
			end
			dqle_pkg::KIND_END: begin
				emit_label();
				name_start = 1'b1;
			end
			dqle_pkg::KIND_TRAILER: begin
				// open label is dropped, only terminator, type and class go out
				push_byte(8'h00, 1'b0, 1'b0);
				push_byte(qt[15:8], 1'b0, 1'b0);
				push_byte(qt[7:0], 1'b0, 1'b0);
				push_byte(qc[15:8], 1'b0, 1'b0);
				push_byte(qc[7:0], 1'b1, trunc_seen);
				label_len = '0;
				name_start = 1'b1;
				trunc_seen = 1'b0;
			end
			default: ;
		endcase
	endtask

	task automatic check_byte();
		wire_byte_t wb;
		if (bytes_due.size() == 0) begin
			$error("out_byte %0h with no word expected", out_byte);
			fails++;
		end else begin
			wb = bytes_due.pop_front();
			if (out_byte !== wb.val) begin
				$error("out_byte expected %0h got %0h", wb.val, out_byte);
				fails++;
			end
			if (is_last !== wb.last) begin
				$error("is_last expected %0b got %0b", wb.last, is_last);
				fails++;
			end
			if (label_overflow !== wb.ovf) begin
				$error("label_overflow expected %0b got %0b", wb.ovf, label_overflow);
				fails++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_due.delete();
			label_len = '0;
			name_start = 1'b1;
			trunc_seen = 1'b0;
			due_cnt = 0;
		end else begin
			if (out_valid && out_ready)
				check_byte();
			if (in_valid && in_ready)
				encode_word(kind, char_byte, query_type, query_class);
			due_cnt = bytes_due.size();
		end
	end

endmodule

### tb/dns_qname_label_encoder_tb.sv
`timescale 1ns / 1ps
// dns_qname_label_encoder_tb: drives dotted names, end and trailer words into
// the encoder with random gaps and back-pressure; depends on dqle_pkg,
// dqle_wire_checker and the encoder itself

module dns_qname_label_encoder_tb;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 210;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [7:0]  char_byte;
	logic [15:0] query_type;
	logic [15:0] query_class;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        is_last;
	logic        label_overflow;
	int          fail_count;
	int          pending;
	bit          steady = 1'b0;
	int          words_sent = 0;

	always #5 clk = ~clk;

	dns_qname_label_encoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.char_byte(char_byte),
		.query_type(query_type),
		.query_class(query_class),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.is_last(is_last),
		.label_overflow(label_overflow)
	);

	dqle_wire_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.char_byte(char_byte),
		.query_type(query_type),
		.query_class(query_class),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.is_last(is_last),
		.label_overflow(label_overflow),
		.fail_count(fail_count),
		.pending(pending)
	);

	task automatic send_word(input logic [1:0] k, input logic [7:0] c,
			input logic [15:0] qt, input logic [15:0] qc);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 19);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		char_byte <= c;
		query_type <= qt;
		query_class <= qc;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic send_char(input logic [7:0] c);
		send_word(dqle_pkg::KIND_CHAR, c, 16'($urandom), 16'($urandom));
	endtask

	task automatic send_end();
		send_word(dqle_pkg::KIND_END, 8'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic send_trailer(input logic [15:0] qt, input logic [15:0] qc);
		send_word(dqle_pkg::KIND_TRAILER, 8'($urandom), qt, qc);
	endtask

	task automatic send_noise();
		send_word(KIND_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
	endtask

	function automatic logic [7:0] label_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == dqle_pkg::DOT_CHAR);
		return c;
	endfunction

	// mostly well-formed names, with stray dots, unused kinds and early trailers
	task automatic send_name(input bit force_long);
		int n_labels;
		int len;
		int r;
		if ($urandom_range(0, 3) == 0)
			send_char(dqle_pkg::DOT_CHAR);
		n_labels = $urandom_range(1, 4);
		for (int i = 0; i < n_labels; i++) begin
			if (force_long && i == 0)
				len = $urandom_range(64, 66);
			else if ($urandom_range(0, 15) == 0)
				len = $urandom_range(60, 66);
			else
				len = $urandom_range(0, 6);
			if (i > 0) begin
				send_char(dqle_pkg::DOT_CHAR);
				if ($urandom_range(0, 5) == 0)
					send_char(dqle_pkg::DOT_CHAR);
			end
			for (int j = 0; j < len; j++) begin
				if ($urandom_range(0, 11) == 0)
					send_noise();
				send_char(($urandom_range(0, 15) == 0) ? dqle_pkg::DOT_CHAR : label_char());
			end
		end
		r = $urandom_range(0, 9);
		if (r == 0) begin
			send_trailer(16'($urandom), 16'($urandom));
		end else if (r == 1) begin
			send_end();
		end else begin
			send_end();
			send_trailer(16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 19);
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = dqle_pkg::KIND_CHAR;
		char_byte = 8'h00;
		query_type = 16'h0000;
		query_class = 16'h0000;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty name
		send_end();
		// leading dot, then a zero-length label between two dots
		send_char(dqle_pkg::DOT_CHAR);
		send_char("a");
		send_char(dqle_pkg::DOT_CHAR);
		send_char(dqle_pkg::DOT_CHAR);
		send_char("b");
		send_end();
		send_trailer(16'hFFFF, 16'hFFFF);
		// trailer without end drops the held characters
		send_char(8'hFF);
		send_char(8'h00);
		send_word(KIND_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_trailer(16'h0000, 16'h0000);
		// first character not a dot, then an empty name after the end
		send_char("x");
		send_end();
		send_end();
		send_trailer(16'h00FF, 16'hFF00);
		// characters after end start a new name
		send_char("q");
		send_end();
		send_char("r");
		send_char(dqle_pkg::DOT_CHAR);
		send_trailer(16'h0001, 16'h0001);

		send_name(1'b1);
		while (words_sent < RANDOM_WORDS) begin
			steady = ($urandom_range(0, 4) == 0);
			send_name(1'b0);
		end
		steady = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("dns_qname_label_encoder: match");
		else
			$display("dns_qname_label_encoder: mismatch");
		$finish;
	end

	initial begin
		#50ms;
		$display("dns_qname_label_encoder: mismatch");
		$finish;
	end

endmodule
